### rtl/hm_pkg.sv
// ----------------------------------------------------------------------------
// hm_pkg
// Shared types, sizes and hash helpers for the linear probing hash map.
// ----------------------------------------------------------------------------
package hm_pkg;

  localparam int INIT_SLOTS = 8;
  localparam int MAX_SLOTS  = 256;
  localparam int KEY_BYTES  = 8;
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
  localparam int ADDR_W     = SLOT_W + 1;
  localparam int IN_W       = 104;
  localparam int OUT_W      = 56;

  typedef enum logic [1:0] {
    CMD_PUT = 2'd0,
    CMD_GET = 2'd1,
    CMD_REM = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2,
    MARK_RSVD  = 2'd3
  } mark_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [63:0]       key;
    logic [31:0]       value;
    logic [SLOT_W-1:0] hash;
  } hm_item_t;

  function automatic logic [63:0] clean_key(input logic [63:0] k);
    logic [63:0] r;
    logic        done;
    r    = '0;
    done = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= KEY_BYTES || k[8*i +: 8] == 8'd0) done = 1'b1;
      if (!done) r[8*i +: 8] = k[8*i +: 8];
    end
    return r;
  endfunction

  // low bits of djb2; key already cleaned
  function automatic logic [SLOT_W-1:0] hash_low(input logic [63:0] k);
    logic [SLOT_W-1:0] h;
    logic              done;
    h    = SLOT_W'(5381);
    done = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (k[8*i +: 8] == 8'd0) done = 1'b1;
      if (!done) h = SLOT_W'(h * 33 + int'(k[8*i +: 8]));
    end
    return h;
  endfunction

endpackage

### rtl/hm_front.sv
// ----------------------------------------------------------------------------
// hm_front
// Accepts request words, cleans the key, hashes it and queues the item.
// ----------------------------------------------------------------------------
module hm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [hm_pkg::IN_W-1:0] s_tdata,  // cmd[1:0], key[65:2], value[97:66]
  input  logic                 clearing,
  output logic                 q_valid,
  input  logic                 q_ready,
  output hm_pkg::hm_item_t     q_item
);
  import hm_pkg::*;

  hm_item_t   q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;
  hm_item_t   item_in;
  logic [63:0] key_c;

  assign key_c         = clean_key(s_tdata[65:2]);
  assign item_in.cmd   = cmd_t'(s_tdata[1:0]);
  assign item_in.key   = key_c;
  assign item_in.value = s_tdata[97:66];
  assign item_in.hash  = hash_low(key_c);

  assign s_tready = (cnt != 2'd2) && !clearing;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = q[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= item_in;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/hm_back.sv
// ----------------------------------------------------------------------------
// hm_back
// Runs queued requests against the two slot banks: probing, growth, result.
// ----------------------------------------------------------------------------
module hm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  hm_pkg::hm_item_t     q_item,
  output logic                 clearing,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [hm_pkg::OUT_W-1:0] m_tdata  // status[2:0], found_value[34:3],
                                            // entry_count[43:35], live_capacity[52:44]
);
  import hm_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_GCLR, S_GRD, S_GCHK, S_GPRD, S_GPCHK,
    S_PRD, S_PCHK, S_INS, S_RESP
  } state_t;

  state_t            state;
  logic              bank;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  ncap;
  logic [CNT_W-1:0]  live;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] step;
  logic [SLOT_W-1:0] gi;
  logic [SLOT_W-1:0] gcnt;
  logic [ADDR_W-1:0] ccnt;
  logic              have_free;
  logic [SLOT_W-1:0] free_idx;
  hm_item_t          cur;
  logic [63:0]       gkey;
  logic [31:0]       gdata;
  status_t           res_status;
  logic [31:0]       res_fv;

  mark_t             mark_mem [2*MAX_SLOTS];
  logic [63:0]       key_mem  [2*MAX_SLOTS];
  logic [31:0]       data_mem [2*MAX_SLOTS];
  mark_t             mark_q;
  logic [63:0]       key_q;
  logic [31:0]       data_q;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              mark_we, key_we, data_we;
  logic [ADDR_W-1:0] w_addr;
  mark_t             w_mark;
  logic [63:0]       w_key;
  logic [31:0]       w_data;

  logic [SLOT_W-1:0] mask;
  logic [SLOT_W-1:0] nmask;
  logic [CNT_W:0]    cap2;
  logic [CNT_W-1:0]  ncap_calc;
  logic [CNT_W+1:0]  load_l, load_r;
  logic              need_grow;
  logic              hit;
  logic              last;
  logic              g_last;
  logic              resp_load;

  assign mask      = SLOT_W'(cap - 1'b1);
  assign nmask     = SLOT_W'(ncap - 1'b1);
  assign cap2      = {cap, 1'b0};
  assign ncap_calc = (cap2 > (CNT_W+1)'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : cap2[CNT_W-1:0];
  assign load_l    = {live, 2'b00};
  assign load_r    = (CNT_W+2)'(cap) + (CNT_W+2)'({cap, 1'b0});
  assign need_grow = (load_l >= load_r) && (cap < CNT_W'(MAX_SLOTS));
  assign hit       = (mark_q == MARK_LIVE) && (key_q == cur.key);
  assign last      = (step == mask);
  assign g_last    = (gi == mask);
  assign resp_load = (state == S_RESP) && (!m_tvalid || m_tready);

  assign q_ready  = (state == S_IDLE);
  assign clearing = (state == S_CLR);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    mark_we = 1'b0;
    key_we  = 1'b0;
    data_we = 1'b0;
    w_addr  = '0;
    w_mark  = MARK_EMPTY;
    w_key   = cur.key;
    w_data  = cur.value;
    unique case (state)
      S_CLR: begin
        mark_we = 1'b1;
        w_addr  = ccnt;
      end
      S_GCLR: begin
        mark_we = 1'b1;
        w_addr  = {~bank, gcnt};
      end
      S_GRD: begin
        rd_en   = 1'b1;
        rd_addr = {bank, gi};
      end
      S_GPRD: begin
        rd_en   = 1'b1;
        rd_addr = {~bank, idx};
      end
      S_GPCHK: begin
        if (mark_q == MARK_EMPTY) begin
          mark_we = 1'b1;
          key_we  = 1'b1;
          data_we = 1'b1;
          w_addr  = {~bank, idx};
          w_mark  = MARK_LIVE;
          w_key   = gkey;
          w_data  = gdata;
        end
      end
      S_PRD: begin
        rd_en   = 1'b1;
        rd_addr = {bank, idx};
      end
      S_PCHK: begin
        w_addr = {bank, idx};
        if (mark_q != MARK_EMPTY && hit) begin
          if (cur.cmd == CMD_PUT) data_we = 1'b1;
          if (cur.cmd == CMD_REM) begin
            mark_we = 1'b1;
            w_mark  = MARK_TOMB;
          end
        end
      end
      S_INS: begin
        mark_we = 1'b1;
        key_we  = 1'b1;
        data_we = 1'b1;
        w_addr  = {bank, free_idx};
        w_mark  = MARK_LIVE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[w_addr] <= w_mark;
    if (key_we) key_mem[w_addr] <= w_key;
    if (data_we) data_mem[w_addr] <= w_data;
    if (rd_en) begin
      mark_q <= mark_mem[rd_addr];
      key_q  <= key_mem[rd_addr];
      data_q <= data_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      bank     <= 1'b0;
      cap      <= CNT_W'(INIT_SLOTS < MAX_SLOTS ? INIT_SLOTS : MAX_SLOTS);
      live     <= '0;
      ccnt     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (resp_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {3'b000, cap, live, res_fv, res_status};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          ccnt <= ccnt + 1'b1;
          if (&ccnt) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur       <= q_item;
            res_fv    <= '0;
            step      <= '0;
            have_free <= 1'b0;
            idx       <= q_item.hash & mask;
            priority if (q_item.cmd == CMD_PUT && need_grow) begin
              ncap  <= ncap_calc;
              gcnt  <= '0;
              state <= S_GCLR;
            end else if (q_item.cmd == CMD_NOP) begin
              res_status <= ST_NOTFOUND;
              state      <= S_RESP;
            end else begin
              state <= S_PRD;
            end
          end
        end
        S_GCLR: begin
          gcnt <= gcnt + 1'b1;
          if (gcnt == nmask) begin
            gi    <= '0;
            state <= S_GRD;
          end
        end
        S_GRD: state <= S_GCHK;
        S_GCHK: begin
          if (mark_q == MARK_LIVE) begin
            gkey  <= key_q;
            gdata <= data_q;
            idx   <= hash_low(key_q) & nmask;
            state <= S_GPRD;
          end else if (g_last) begin
            bank  <= ~bank;
            cap   <= ncap;
            idx   <= cur.hash & nmask;
            state <= S_PRD;
          end else begin
            gi    <= gi + 1'b1;
            state <= S_GRD;
          end
        end
        S_GPRD: state <= S_GPCHK;
        S_GPCHK: begin
          priority if (mark_q != MARK_EMPTY) begin
            idx   <= (idx + 1'b1) & nmask;
            state <= S_GPRD;
          end else if (g_last) begin
            bank  <= ~bank;
            cap   <= ncap;
            idx   <= cur.hash & nmask;
            state <= S_PRD;
          end else begin
            gi    <= gi + 1'b1;
            state <= S_GRD;
          end
        end
        S_PRD: state <= S_PCHK;
        S_PCHK: begin
          if (cur.cmd == CMD_PUT) begin
            priority if (mark_q == MARK_EMPTY) begin
              if (!have_free) free_idx <= idx;
              state <= S_INS;
            end else if (hit) begin
              res_status <= ST_UPDATED;
              state      <= S_RESP;
            end else begin
              if (mark_q != MARK_LIVE && !have_free) begin
                have_free <= 1'b1;
                free_idx  <= idx;
              end
              if (last) begin
                if (have_free || mark_q != MARK_LIVE) begin
                  state <= S_INS;
                end else begin
                  res_status <= ST_FULL;
                  state      <= S_RESP;
                end
              end else begin
                step  <= step + 1'b1;
                idx   <= (idx + 1'b1) & mask;
                state <= S_PRD;
              end
            end
          end else begin
            priority if (mark_q == MARK_EMPTY) begin
              res_status <= ST_NOTFOUND;
              state      <= S_RESP;
            end else if (hit) begin
              if (cur.cmd == CMD_GET) begin
                res_status <= ST_FOUND;
                res_fv     <= data_q;
              end else begin
                res_status <= ST_REMOVED;
                live       <= live - 1'b1;
              end
              state <= S_RESP;
            end else if (last) begin
              res_status <= ST_NOTFOUND;
              state      <= S_RESP;
            end else begin
              step  <= step + 1'b1;
              idx   <= (idx + 1'b1) & mask;
              state <= S_PRD;
            end
          end
        end
        S_INS: begin
          live       <= live + 1'b1;
          res_status <= ST_INSERTED;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (resp_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/linear_probe_hash_map.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// Key-value map with djb2 hashing, linear probing and bank-swap growth.
// ----------------------------------------------------------------------------
// Request path: S_IDLE, then S_PRD and S_PCHK per probed slot, S_INS on insert, S_RESP.
// A growth clears the new bank's marks, reads each old slot and reprobes its live keys.
// Throughput: one request at a time in the back end, set by the single
// read port of the slot memories; a two-word queue takes requests meanwhile.
// Reset: a pass over all 512 slot addresses clears slot marks; no request is accepted during it.
module linear_probe_hash_map (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [hm_pkg::IN_W-1:0]  s_tdata,  // cmd[1:0], key[65:2], value[97:66]
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [hm_pkg::OUT_W-1:0] m_tdata   // status[2:0], found_value[34:3],
                                             // entry_count[43:35], live_capacity[52:44]
);
  import hm_pkg::*;

  logic     q_valid;
  logic     q_ready;
  hm_item_t q_item;
  logic     clearing;

  hm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  hm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### rtl/linear_probe_hash_map_checker.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_map_checker
// Port-level checks on result words of the hash map.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [hm_pkg::OUT_W-1:0] m_tdata
);
  import hm_pkg::*;

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_cap_pow2: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tdata[52:44]) && m_tdata[52:44] >= 9'd8)
    else $error("capacity not a power of two");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[43:35] <= m_tdata[52:44] && m_tdata[2:0] <= ST_FULL)
    else $error("count or status out of range");

  a_fv_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != ST_FOUND |-> m_tdata[34:3] == 32'd0)
    else $error("found value set without a hit");

endmodule

bind linear_probe_hash_map linear_probe_hash_map_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
